// ===== hw/rtl/pcg32_pkg.sv =====
// Shared types and constants for the PCG32 XSH-RR random generator.
package pcg32_pkg;

   localparam int unsigned BoundWidth = 64;
   localparam int unsigned CsrIndexWidth = 4;

   localparam logic [63:0] LcgMult = 64'd6364136223846793005;
   localparam logic [63:0] BoundMask = {64{1'b1}} >> (64 - BoundWidth);
   // State after seeding with seed 0 and stream 0.
   localparam logic [63:0] LcgResetState = 64'd6364136223846793006;
   localparam logic [63:0] IncResetValue = 64'd1;

   localparam logic [CsrIndexWidth-1:0] CsrSeedValue = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CsrStreamSelect = CsrIndexWidth'(1);

   typedef enum logic [2:0] {
      KIND_RESEED  = 3'd0,
      KIND_DRAW32  = 3'd1,
      KIND_DRAW64  = 3'd2,
      KIND_UNIFORM = 3'd3,
      KIND_BOUNDED = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV_LIMIT,
      ST_DIV_MOD,
      ST_FINISH
   } seq_state_type;

   // XSH-RR output permutation of the pre-step state.
   function automatic logic [31:0] xsh_rr(input logic [63:0] prev);
      logic [63:0] xs;
      logic [31:0] mixed;
      logic [4:0]  rot;
      logic [63:0] dbl;
      xs    = (prev >> 18) ^ prev;
      mixed = xs[58:27];
      rot   = prev[63:59];
      dbl   = {mixed, mixed} >> rot;
      return dbl[31:0];
   endfunction

endpackage

// ===== hw/rtl/pcg32_random_generator.sv =====
// PCG32 XSH-RR generator: shared 32x32 multiplier LCG and bit-serial remainder unit.
//
//  channel | ports                                  | dir | handshake
//  --------+----------------------------------------+-----+------------------------
//  req     | req_valid, req_stall, req_kind, req_bound | in  | valid & !stall
//  rsp     | rsp_valid, rsp_stall, rsp_value        | out | valid & !stall
//  csr     | csr_valid, csr_ready, csr_index, csr_wdata | in  | valid & ready
//
// Each LCG step runs the lo*lo, hi*lo and lo*hi partial products on the one 32x32 multiplier; a
// finishing state loads the result. Reseed and 32-bit draws take one LCG step, 64-bit and uniform
// draws two; zero bound and unused kinds go to finish. Bounded draws run a bit-serial remainder for
// the rejection limit, 64-bit draws (again on rejection), a final remainder and the finish. The next
// beat can be accepted in the cycle after the result loads. Reset is synchronous and restores seed 0,
// stream 0. A new beat is taken while a result waits; a stalled result holds only the finishing cycle.
module pcg32_random_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_kind,
   input  logic [63:0]                        req_bound,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [63:0]                        rsp_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcg32_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [63:0]                        csr_wdata
);
   import pcg32_pkg::*;

   seq_state_type state_ff, state_in;
   logic [63:0] lcg_ff, lcg_in;
   logic [63:0] inc_ff, inc_in;
   logic [63:0] seed_ff;
   logic [62:0] stream_ff;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  mph_ff, mph_in;
   logic        wsel_ff, wsel_in;
   logic [31:0] hi_ff, hi_in;
   kind_type    kind_ff, kind_in;
   logic [63:0] bound_ff, bound_in;
   logic [63:0] limit_ff, limit_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] lcg_next;
   logic [31:0] word;
   logic [63:0] draw;
   logic [63:0] req_bound_eff;
   logic [63:0] new_inc;
   logic [64:0] rem_sh;
   logic        rem_ge;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   assign req_bound_eff = req_bound & BoundMask;
   assign new_inc = {stream_ff, 1'b1};
   assign word = xsh_rr(lcg_ff);
   assign draw = {hi_ff, word};

   always_comb begin
      case (mph_ff)
         2'd0: begin
            mul_a = lcg_ff[31:0];
            mul_b = LcgMult[31:0];
         end
         2'd1: begin
            mul_a = lcg_ff[63:32];
            mul_b = LcgMult[31:0];
         end
         default: begin
            mul_a = lcg_ff[31:0];
            mul_b = LcgMult[63:32];
         end
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);
   assign lcg_next = acc_ff + {prod[31:0], 32'd0};

   assign rem_sh = {rem_ff, num_ff[63]};
   assign rem_ge = (rem_sh >= {1'b0, bound_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lcg_ff       <= LcgResetState;
         inc_ff       <= IncResetValue;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lcg_ff       <= lcg_in;
         inc_ff       <= inc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= 64'd0;
         stream_ff <= 63'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CsrSeedValue:    seed_ff <= csr_wdata;
            CsrStreamSelect: stream_ff <= csr_wdata[62:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      mph_ff       <= mph_in;
      wsel_ff      <= wsel_in;
      hi_ff        <= hi_in;
      kind_ff      <= kind_in;
      bound_ff     <= bound_in;
      limit_ff     <= limit_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      state_in     = state_ff;
      lcg_in       = lcg_ff;
      inc_in       = inc_ff;
      acc_in       = acc_ff;
      mph_in       = mph_ff;
      wsel_in      = wsel_ff;
      hi_in        = hi_ff;
      kind_in      = kind_ff;
      bound_in     = bound_ff;
      limit_in     = limit_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               bound_in = req_bound_eff;
               mph_in   = 2'd0;
               wsel_in  = 1'b0;
               case (kind_type'(req_kind))
                  KIND_RESEED: begin
                     lcg_in   = new_inc + seed_ff;
                     inc_in   = new_inc;
                     state_in = ST_STEP;
                  end
                  KIND_DRAW32, KIND_DRAW64, KIND_UNIFORM: begin
                     state_in = ST_STEP;
                  end
                  KIND_BOUNDED: begin
                     if (req_bound_eff == 64'd0) begin
                        res_in   = 64'd0;
                        state_in = ST_FINISH;
                     end else begin
                        num_in   = 64'd0 - req_bound_eff;
                        rem_in   = 64'd0;
                        cnt_in   = 6'd0;
                        state_in = ST_DIV_LIMIT;
                     end
                  end
                  default: begin
                     res_in   = 64'd0;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_STEP: begin
            case (mph_ff)
               2'd0: begin
                  acc_in = prod + inc_ff;
                  mph_in = 2'd1;
               end
               2'd1: begin
                  acc_in = lcg_next;
                  mph_in = 2'd2;
               end
               default: begin
                  lcg_in = lcg_next;
                  mph_in = 2'd0;
                  case (kind_ff)
                     KIND_RESEED: begin
                        res_in   = 64'd0;
                        state_in = ST_FINISH;
                     end
                     KIND_DRAW32: begin
                        res_in   = {32'd0, word};
                        state_in = ST_FINISH;
                     end
                     default: begin
                        if (!wsel_ff) begin
                           hi_in   = word;
                           wsel_in = 1'b1;
                        end else begin
                           wsel_in = 1'b0;
                           if (kind_ff == KIND_UNIFORM) begin
                              res_in   = draw >> 11;
                              state_in = ST_FINISH;
                           end else if (kind_ff == KIND_BOUNDED) begin
                              if (draw >= limit_ff) begin
                                 num_in   = draw;
                                 rem_in   = 64'd0;
                                 cnt_in   = 6'd0;
                                 state_in = ST_DIV_MOD;
                              end
                           end else begin
                              res_in   = draw;
                              state_in = ST_FINISH;
                           end
                        end
                     end
                  endcase
               end
            endcase
         end

         ST_DIV_LIMIT, ST_DIV_MOD: begin
            rem_in = rem_ge ? 64'(rem_sh - {1'b0, bound_ff}) : rem_sh[63:0];
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (state_ff == ST_DIV_LIMIT) begin
                  limit_in = rem_in;
                  mph_in   = 2'd0;
                  wsel_in  = 1'b0;
                  state_in = ST_STEP;
               end else begin
                  res_in   = rem_in;
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_inc_odd: assert property (@(posedge clock) disable iff (reset) inc_ff[0])
      else $error("stream increment lost its low bit");

   a_rem_below_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_LIMIT || state_ff == ST_DIV_MOD) |-> (rem_ff < bound_ff))
      else $error("partial remainder not below divisor");

   a_div_starts_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_DIV_LIMIT) |=> (cnt_ff == 6'd0 && rem_ff == 64'd0))
      else $error("remainder unit not cleared at start");

   a_bounded_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && kind_ff == KIND_BOUNDED && bound_ff != 64'd0)
         |-> (res_ff < bound_ff))
      else $error("bounded draw out of range");

   a_rsp_load_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && state_in == ST_IDLE) |=> (rsp_valid_ff && !req_stall))
      else $error("result load did not release the sequencer");

endmodule
